// ----- hw/rtl/bms_pkg.sv -----
// Shared types and constants of the stepper move sequencer.
// Depends on nothing; every other file of the block but bms_stream_if uses it by scoped names.
`default_nettype none
package bms_pkg;

  localparam int POS_BITS = 24;
  localparam int BL_BITS  = 16;
  localparam int CNT_BITS = POS_BITS + 1;

  // Command codes of the func field.
  localparam logic [2:0] FUNC_TICK     = 3'd0;
  localparam logic [2:0] FUNC_REL_MOVE = 3'd1;
  localparam logic [2:0] FUNC_ABS_MOVE = 3'd2;
  localparam logic [2:0] FUNC_ABORT    = 3'd3;
  localparam logic [2:0] FUNC_ZERO     = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_MAX_POSITION    = 2'd0;
  localparam logic [1:0] REG_BACKLASH_ENABLE = 2'd1;
  localparam logic [1:0] REG_BACKLASH_STEPS  = 2'd2;
  localparam logic [1:0] REG_REVERSED        = 2'd3;

  localparam logic [POS_BITS-1:0] RESET_MAX_POSITION  = 24'd2048000;
  localparam logic [POS_BITS-1:0] RESET_POSITION      = 24'd1024000;
  localparam logic [BL_BITS-1:0]  RESET_BACKLASH      = 16'd650;

  typedef struct packed {
    logic [2:0]          func;
    logic                move_dir;
    logic [POS_BITS-1:0] step_amount;
    logic [POS_BITS-1:0] target_position;
  } cmd_t;

  typedef struct packed {
    logic                step_pulse;
    logic                dir_level;
    logic [POS_BITS-1:0] position_now;
    logic                moving;
    logic [CNT_BITS-1:0] remaining;
    logic                move_done;
    logic                done_aborted;
  } res_t;

  typedef struct packed {
    logic [POS_BITS-1:0] max_position;
    logic                backlash_enable;
    logic [BL_BITS-1:0]  backlash_steps;
    logic                reversed;
  } cfg_t;

  typedef struct packed {
    logic [POS_BITS-1:0] position;
    logic                direction;
    logic                active;
    logic [CNT_BITS-1:0] total_count;
    logic [BL_BITS-1:0]  move_backlash;
    logic [CNT_BITS-1:0] steps_taken;
    logic                abort_pending;
  } seq_state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/bms_stream_if.sv -----
// Valid/ready channel carrying one payload item per handshake.
// The payload type is a parameter.
`default_nettype none
interface bms_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/bms_cfg_regs.sv -----
// Configuration register file of the sequencer.
// Uses bms_pkg for the register indexes, reset values and cfg_t.
`default_nettype none
module bms_cfg_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         we,
  input  wire logic [1:0]                   index,
  input  wire logic [bms_pkg::POS_BITS-1:0] data,
  output bms_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_position    <= bms_pkg::RESET_MAX_POSITION;
      cfg.backlash_enable <= 1'b1;
      cfg.backlash_steps  <= bms_pkg::RESET_BACKLASH;
      cfg.reversed        <= 1'b0;
    end else if (we) begin
      unique case (index)
        bms_pkg::REG_MAX_POSITION:    cfg.max_position    <= data;
        bms_pkg::REG_BACKLASH_ENABLE: cfg.backlash_enable <= data[0];
        bms_pkg::REG_BACKLASH_STEPS:  cfg.backlash_steps  <= data[bms_pkg::BL_BITS-1:0];
        bms_pkg::REG_REVERSED:        cfg.reversed        <= data[0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/bms_seq_core.sv -----
// Move sequencer state and its single-pass next-state logic.
// Uses bms_pkg for cmd_t, res_t, cfg_t and seq_state_t.
`default_nettype none
module bms_seq_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire bms_pkg::cmd_t cmd,
  input  wire bms_pkg::cfg_t cfg,
  output bms_pkg::res_t      res
);

  localparam int CNT = bms_pkg::CNT_BITS;
  localparam int BL  = bms_pkg::BL_BITS;
  localparam int POS = bms_pkg::POS_BITS;

  bms_pkg::seq_state_t st;
  bms_pkg::seq_state_t st_next;

  function automatic bms_pkg::seq_state_t start_move(bms_pkg::seq_state_t s, logic dir,
                                                     logic [POS-1:0] steps, bms_pkg::cfg_t c);
    bms_pkg::seq_state_t r;
    logic [BL-1:0]       bl;
    r  = s;
    bl = (dir && c.backlash_enable && (steps != '0)) ? c.backlash_steps : '0;
    r.direction     = dir;
    r.total_count   = {1'b0, steps} + {{(CNT-BL){1'b0}}, bl};
    r.move_backlash = bl;
    r.steps_taken   = '0;
    r.abort_pending = 1'b0;
    r.active        = 1'b1;
    return r;
  endfunction

  function automatic bms_pkg::seq_state_t start_unwind(bms_pkg::seq_state_t s);
    bms_pkg::seq_state_t r;
    r = s;
    r.direction     = 1'b0;
    r.total_count   = {{(CNT-BL){1'b0}}, s.move_backlash};
    r.steps_taken   = '0;
    r.abort_pending = 1'b0;
    r.active        = 1'b1;
    return r;
  endfunction

  function automatic bms_pkg::seq_state_t to_idle(bms_pkg::seq_state_t s);
    bms_pkg::seq_state_t r;
    r = s;
    r.active        = 1'b0;
    r.total_count   = '0;
    r.move_backlash = '0;
    r.steps_taken   = '0;
    r.abort_pending = 1'b0;
    return r;
  endfunction

  logic           unwinding;
  logic           limit;
  logic [CNT-1:0] taken_inc;
  logic [CNT-1:0] move_part;
  logic           pulse;
  logic           done;
  logic           aborted;

  always_comb begin
    st_next   = st;
    pulse     = 1'b0;
    done      = 1'b0;
    aborted   = 1'b0;
    unwinding = (st.move_backlash != '0) &&
                ({{(CNT-BL){1'b0}}, st.move_backlash} == st.total_count);
    limit     = st.direction ? (st.position >= cfg.max_position) : (st.position == '0);
    taken_inc = st.steps_taken + 1'b1;
    // Steps beyond the move part are backlash overshoot and leave position alone.
    move_part = st.total_count - {{(CNT-BL){1'b0}}, st.move_backlash};

    unique case (cmd.func)
      bms_pkg::FUNC_REL_MOVE: st_next = start_move(st, cmd.move_dir, cmd.step_amount, cfg);
      bms_pkg::FUNC_ABS_MOVE: begin
        if (cmd.target_position < st.position)
          st_next = start_move(st, 1'b0, st.position - cmd.target_position, cfg);
        else
          st_next = start_move(st, 1'b1, cmd.target_position - st.position, cfg);
      end
      bms_pkg::FUNC_ABORT: begin
        if (st.active) st_next.abort_pending = 1'b1;
      end
      bms_pkg::FUNC_ZERO: st_next.position = '0;
      bms_pkg::FUNC_TICK: begin
        if (st.active) begin
          if ((st.abort_pending && !unwinding) || (limit && !unwinding
              && (st.total_count != '0))) begin
            if (st.move_backlash != '0) begin
              st_next = start_unwind(st);
            end else begin
              st_next = to_idle(st);
              done    = 1'b1;
              aborted = 1'b1;
            end
          end else if (st.total_count == '0) begin
            st_next = to_idle(st);
            done    = 1'b1;
          end else if (limit) begin
            // A limit hit during the unwind only flags the abort; the unwind stalls.
            st_next.abort_pending = 1'b1;
          end else begin
            pulse = 1'b1;
            st_next.steps_taken = taken_inc;
            if (taken_inc <= move_part) begin
              if (st.direction) st_next.position = st.position + 1'b1;
              else              st_next.position = st.position - 1'b1;
            end
            if (taken_inc == st.total_count) begin
              if ((st.move_backlash != '0) && !unwinding) begin
                st_next = start_unwind(st_next);
              end else begin
                st_next = to_idle(st_next);
                done    = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase

    res.step_pulse   = pulse;
    res.dir_level    = st_next.direction ^ cfg.reversed;
    res.position_now = st_next.position;
    res.moving       = st_next.active;
    res.remaining    = st_next.active ? (st_next.total_count - st_next.steps_taken) : '0;
    res.move_done    = done;
    res.done_aborted = aborted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.position      <= bms_pkg::RESET_POSITION;
      st.direction     <= 1'b0;
      st.active        <= 1'b0;
      st.total_count   <= '0;
      st.move_backlash <= '0;
      st.steps_taken   <= '0;
      st.abort_pending <= 1'b0;
    end else if (accept) begin
      st <= st_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/bms_out_reg.sv -----
// Result register between the sequencer logic and the result channel.
// Uses bms_pkg for res_t; its free signal gates acceptance of the next item.
`default_nettype none
module bms_out_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire bms_pkg::res_t res,
  output logic               free,
  bms_stream_if.source       status
);

  logic valid;

  // The register is free when empty or when its item leaves in this cycle.
  assign free         = !valid || status.ready;
  assign status.valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (status.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) status.data <= res;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/stepper_move_backlash_sequencer_top.sv -----
// Stepper move sequencer with backlash compensation. Every command item
// (tick, relative or absolute move, abort, zero position) is handled by the
// combinational sequencer logic and yields exactly one status item in the
// next cycle from the result register; a new item is accepted every cycle
// as long as the result register is empty or drains in that cycle, so the
// sustained rate is one item per cycle. Uses bms_pkg and bms_stream_if.
`default_nettype none
module stepper_move_backlash_sequencer_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [bms_pkg::POS_BITS-1:0] cfg_data,
  bms_stream_if.sink                        cmd,
  bms_stream_if.source                      status
);

  bms_pkg::cfg_t cfg;
  bms_pkg::res_t res;
  bms_pkg::cmd_t cmd_item;
  logic          free;
  logic          accept;

  assign cmd.ready = free;
  assign accept    = cmd.valid && free;
  assign cmd_item  = cmd.data;

  bms_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  bms_seq_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (cmd_item),
    .cfg    (cfg),
    .res    (res)
  );

  bms_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .res    (res),
    .free   (free),
    .status (status)
  );

endmodule
`default_nettype wire
